>>> design/unsigned_wide_divider_core_assert.svh
// unsigned_wide_divider_core_assert.svh: assertion macros for the divider checks
// needs clk and rst_n in the scope where the macros are used
`ifndef UNSIGNED_WIDE_DIVIDER_CORE_ASSERT_SVH
`define UNSIGNED_WIDE_DIVIDER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider check failed");

// next-cycle implication, checked outside reset
`define UWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider check failed");

`endif

>>> design/uwd_pkg.sv
// uwd_pkg.sv: shared constants and types for the unsigned wide divider
// no dependencies
`default_nettype none

package uwd_pkg;

    // fixed field width of every operand and result on the ports
    localparam int UWD_DATA_W  = 64;
    // default operand width used inside the divider
    localparam int UWD_WIDTH   = 64;
    localparam int UWD_IN_W    = 2 * UWD_DATA_W;
    localparam int UWD_OUT_W   = 2 * UWD_DATA_W;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic step;
    } uwd_ctrl_t;

endpackage

`default_nettype wire

>>> design/uwd_datapath.sv
// uwd_datapath.sv: partial remainder, quotient shifter and the shared subtract unit
// depends on uwd_pkg
`default_nettype none

module uwd_datapath
    import uwd_pkg::*;
#(
    parameter int WIDTH = UWD_WIDTH
)
(
    input  wire logic                  clk,
    input  wire uwd_ctrl_t             ctrl,
    input  wire logic [UWD_DATA_W-1:0] dividend,
    input  wire logic [UWD_DATA_W-1:0] divisor,
    output logic      [UWD_DATA_W-1:0] quotient,
    output logic      [UWD_DATA_W-1:0] remainder,
    output logic                       divide_by_zero
);

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] div_reg;
    logic             dz_reg;
    logic             dz_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // one restoring step: shift the next dividend bit in, subtract if it fits
    assign trial = {acc_reg, quo_reg[WIDTH-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        dz_next  = dz_reg;
        priority if (ctrl.load)
        begin
            acc_next = '0;
            quo_next = dividend[WIDTH-1:0];
            dz_next  = (divisor[WIDTH-1:0] == '0);
        end
        else if (ctrl.step)
        begin
            acc_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
        end
        else
        begin
            acc_next = acc_reg;
            quo_next = quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dz_reg  <= dz_next;
        if (ctrl.load)
        begin
            div_reg <= divisor[WIDTH-1:0];
        end
    end

    // a zero divisor leaves the dividend as remainder; only the quotient needs forcing
    assign quotient       = dz_reg ? '0 : UWD_DATA_W'(quo_reg);
    assign remainder      = UWD_DATA_W'(acc_reg);
    assign divide_by_zero = dz_reg;

endmodule

`default_nettype wire

>>> design/unsigned_wide_divider_core.sv
// unsigned_wide_divider_core.sv: top level of the unsigned restoring divider
// depends on uwd_pkg and uwd_datapath
//
// usage:
//   s_axis carries one operand pair per beat: tdata holds dividend in the low
//   64 bits and divisor in the high 64 bits. only the low WIDTH bits of each
//   operand are used.
//   m_axis returns one result per beat: tdata holds quotient in the low 64
//   bits and remainder in the high 64 bits, tuser holds divide_by_zero.
//   a zero divisor sets divide_by_zero, with quotient 0 and remainder equal to
//   the dividend.
//   the result comes from the shared shift-subtract unit, one quotient bit per
//   cycle after the input beat is accepted; the block handles one item at a
//   time and s_axis_tready is low from accept until the result beat is taken.
//   a stalled receiver holds the result on m_axis; no new input is taken then.
//   reset returns the block to idle with s_axis_tready high and no result.
`default_nettype none

module unsigned_wide_divider_core
    import uwd_pkg::*;
#(
    parameter int WIDTH = UWD_WIDTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [UWD_IN_W-1:0]  s_axis_tdata,   // dividend, divisor
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [UWD_OUT_W-1:0] m_axis_tdata,   // quotient, remainder
    output logic                      m_axis_tuser    // divide_by_zero
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    uwd_ctrl_t        ctrl;
    logic             in_beat;
    logic [UWD_DATA_W-1:0] quotient;
    logic [UWD_DATA_W-1:0] remainder;
    logic                  divide_by_zero;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_DONE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign ctrl.load = in_beat;
    assign ctrl.step = (state_reg == S_RUN);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_RUN;
                    cnt_next   = CNT_W'(WIDTH);
                end
            end
            S_RUN:
            begin
                // counts quotient bits still to produce
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    uwd_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk            (clk),
        .ctrl           (ctrl),
        .dividend       (s_axis_tdata[UWD_DATA_W-1:0]),
        .divisor        (s_axis_tdata[UWD_IN_W-1:UWD_DATA_W]),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

    assign m_axis_tdata = {remainder, quotient};
    assign m_axis_tuser = divide_by_zero;

endmodule

`default_nettype wire

>>> design/uwd_checker.sv
// uwd_checker.sv: port-level checks on the divider top level, bound to it
// depends on uwd_pkg and unsigned_wide_divider_core_assert.svh
`default_nettype none

`include "unsigned_wide_divider_core_assert.svh"

module uwd_checker
    import uwd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [UWD_OUT_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // one item in flight: never ready for input while a result is offered
    `UWD_ASSERT_NOW(a_one_in_flight, 1'b1, !(s_axis_tready && m_axis_tvalid))
    // an accepted beat closes the input and cannot produce a result at once
    `UWD_ASSERT_NEXT(a_busy_after_accept, in_beat, !s_axis_tready && !m_axis_tvalid)
    // a stalled result beat holds
    `UWD_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // zero divisor gives zero quotient
    `UWD_ASSERT_NOW(a_dz_quotient, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[UWD_DATA_W-1:0] == '0)

endmodule

bind unsigned_wide_divider_core uwd_checker u_checker (.*);

`default_nettype wire

>>> verif/unsigned_wide_divider_core_checker.sv
// unsigned_wide_divider_core_checker.sv: watches both streams of the divider, predicts
// quotient, remainder and divide-by-zero for every operand beat and compares results
// depends on uwd_pkg
`timescale 1ns / 100ps
`default_nettype none

module unsigned_wide_divider_core_checker
    import uwd_pkg::*;
#(
    parameter int WIDTH = UWD_WIDTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [UWD_IN_W-1:0]  s_axis_tdata,   // dividend, divisor
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [UWD_OUT_W-1:0] m_axis_tdata,   // quotient, remainder
    input  wire logic                 m_axis_tuser,   // divide_by_zero
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic [UWD_DATA_W-1:0] quotient;
        logic [UWD_DATA_W-1:0] remainder;
        logic                  div_by_zero;
    } division_t;

    division_t awaited_divisions[$];
    division_t want;
    division_t got;

    function automatic int leading_one(input logic [UWD_DATA_W-1:0] value);
        int pos;
        pos = 0;
        for (int i = 1; i < WIDTH; i++)
        begin
            if (value[i])
                pos = i;
        end
        return pos;
    endfunction

    // restoring shift-subtract, divisor aligned under the dividend's leading one
    function automatic division_t divide_restoring(input logic [UWD_DATA_W-1:0] dividend,
                                                   input logic [UWD_DATA_W-1:0] divisor);
        division_t res;
        logic [UWD_DATA_W-1:0] mask;
        logic [UWD_DATA_W-1:0] num;
        logic [UWD_DATA_W-1:0] den;
        logic [UWD_DATA_W-1:0] aligned;
        int span;
        mask = {UWD_DATA_W{1'b1}} >> (UWD_DATA_W - WIDTH);
        num = dividend & mask;
        den = divisor & mask;
        res.quotient = '0;
        res.remainder = num;
        res.div_by_zero = 1'b0;
        if (den == '0)
        begin
            res.div_by_zero = 1'b1;
        end
        else if (num >= den)
        begin
            span = leading_one(num) - leading_one(den);
            aligned = (den << span) & mask;
            for (int i = 0; i <= span; i++)
            begin
                res.quotient = (res.quotient << 1) & mask;
                if (res.remainder >= aligned)
                begin
                    res.remainder = res.remainder - aligned;
                    res.quotient[0] = 1'b1;
                end
                aligned = aligned >> 1;
            end
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result first: a beat taken in the same cycle belongs to an older operand pair
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.quotient    = m_axis_tdata[UWD_DATA_W-1:0];
                got.remainder   = m_axis_tdata[2*UWD_DATA_W-1:UWD_DATA_W];
                got.div_by_zero = m_axis_tuser;
                if (awaited_divisions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat q=%h r=%h dz=%b",
                                 $realtime, got.quotient, got.remainder, got.div_by_zero);
                end
                else
                begin
                    want = awaited_divisions.pop_front();
                    if (got.quotient !== want.quotient || got.remainder !== want.remainder
                        || got.div_by_zero !== want.div_by_zero)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch exp q=%h r=%h dz=%b got q=%h r=%h dz=%b",
                                     $realtime, want.quotient, want.remainder, want.div_by_zero,
                                     got.quotient, got.remainder, got.div_by_zero);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_divisions.push_back(divide_restoring(s_axis_tdata[UWD_DATA_W-1:0],
                    s_axis_tdata[2*UWD_DATA_W-1:UWD_DATA_W]));
            outstanding <= awaited_divisions.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/unsigned_wide_divider_core_tb.sv
// unsigned_wide_divider_core_tb.sv: top of the divider testbench, drives operand beats
// and result backpressure in four phases of input idles and result stalls, and gives the verdict
// depends on uwd_pkg, unsigned_wide_divider_core and unsigned_wide_divider_core_checker
`timescale 1ns / 100ps
`default_nettype none

module unsigned_wide_divider_core_tb;

    import uwd_pkg::*;

    localparam int DIV_WIDTH      = UWD_WIDTH;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [UWD_IN_W-1:0]  s_axis_tdata = '0;   // dividend, divisor
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [UWD_OUT_W-1:0] m_axis_tdata;        // quotient, remainder
    logic                 m_axis_tuser;        // divide_by_zero

    int   mismatches;
    int   outstanding;
    int   rx_stall_pct = 0;
    int   tx_idle_pct;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;

    unsigned_wide_divider_core #(
        .WIDTH(DIV_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    unsigned_wide_divider_core_checker #(
        .WIDTH(DIV_WIDTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off when requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL unsigned_wide_divider_core");
        $finish;
    end

    // random operand with the given number of significant bits
    function automatic logic [UWD_DATA_W-1:0] rand_operand(input int bits);
        logic [UWD_DATA_W-1:0] value;
        value = {$urandom, $urandom};
        if (bits <= 0)
            return '0;
        return value >> (UWD_DATA_W - bits);
    endfunction

    // valid stays high across back-to-back beats; within this task it only drops during idle gaps
    task automatic send_operands(input logic [UWD_DATA_W-1:0] dividend,
                                 input logic [UWD_DATA_W-1:0] divisor);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {divisor, dividend};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random_division();
        logic [UWD_DATA_W-1:0] num;
        logic [UWD_DATA_W-1:0] den;
        int kind;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            num = rand_operand(64);
            den = rand_operand(64);
        end
        else if (kind < 68)
        begin
            // unequal lengths give long shift-subtract runs
            num = rand_operand($urandom_range(64, 1));
            den = rand_operand($urandom_range(64, 1));
        end
        else if (kind < 76)
        begin
            num = rand_operand($urandom_range(64, 0));
            den = '0;
        end
        else if (kind < 84)
        begin
            den = rand_operand($urandom_range(64, 2));
            // the remainder below needs a nonzero divisor
            if (den == '0)
                den = 64'd1;
            num = den - 1 - (rand_operand(64) % den);
        end
        else if (kind < 92)
        begin
            den = rand_operand($urandom_range(64, 1));
            num = den + rand_operand($urandom_range(3, 0));
        end
        else
        begin
            num = rand_operand($urandom_range(8, 1));
            den = rand_operand($urandom_range(8, 1));
        end
        send_operands(num, den);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        logic [UWD_DATA_W-1:0] all_ones;
        logic [UWD_DATA_W-1:0] top_bit;
        all_ones = '1;
        top_bit = {1'b1, {(UWD_DATA_W-1){1'b0}}};
        tx_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: zero divisor, dividend below divisor, extremes
        send_operands('0, '0);
        send_operands(all_ones, '0);
        send_operands(64'd1, '0);
        send_operands('0, 64'd1);
        send_operands(all_ones, 64'd1);
        send_operands(all_ones, all_ones);
        send_operands(64'd1, all_ones);
        send_operands(all_ones - 1, all_ones);
        send_operands('0, all_ones);
        send_operands(top_bit, 64'd1);
        send_operands(top_bit, top_bit);
        send_operands(all_ones, top_bit);
        send_operands(top_bit - 1, top_bit);
        send_operands(64'd1, 64'd1);
        send_operands(all_ones, 64'd3);
        send_operands(all_ones, 64'h0000_0000_ffff_ffff);
        send_operands(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_operands(64'hfedc_ba98_7654_3210, 64'h0123_4567_89ab_cdef);
        send_operands(64'd100, 64'd7);
        send_operands(64'd7, 64'd100);
        send_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 84; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 84; end
                default: begin tx_idle_pct = 6; rx_stall_pct <= 6; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long result hold-off while the operand side keeps offering beats
                if (phase == 0 && n == 100)
                    hold_req <= ~hold_req;
                send_random_division();
            end
            drain_results();
        end

        repeat (DIV_WIDTH + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS unsigned_wide_divider_core");
        else
            $display("FAIL unsigned_wide_divider_core");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+design
design/uwd_pkg.sv
design/uwd_datapath.sv
design/unsigned_wide_divider_core.sv
design/uwd_checker.sv
verif/unsigned_wide_divider_core_checker.sv
verif/unsigned_wide_divider_core_tb.sv
